>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

>>> hw/rtl/ptsb_pkg.sv
// ---------------------------------------------------------------------------
// Periodic timer slot bank package
// Shared types, codes and constants for the slot ring and its head logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptsb_pkg;

    localparam int SLOT_DEPTH         = 16;
    localparam int DEFAULT_SLOT_COUNT = 16;
    localparam int DEFAULT_TICK_MS    = 50;

    localparam int INTERVAL_W = 11;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = '1;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    localparam logic [1:0] KIND_REGISTERED = 2'd0;
    localparam logic [1:0] KIND_TOO_SHORT  = 2'd1;
    localparam logic [1:0] KIND_FULL       = 2'd2;
    localparam logic [1:0] KIND_FIRED      = 2'd3;

    typedef struct packed {
        logic                  active;
        logic [INTERVAL_W-1:0] interval;
        logic [INTERVAL_W-1:0] elapsed;
    } t_slot;

    typedef struct packed {
        logic fire;
        logic place;
    } t_head_res;

endpackage

>>> hw/rtl/ptsb_cell.sv
// ---------------------------------------------------------------------------
// Slot cell
// Holds the state of one timer slot and takes its neighbor's state on shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptsb_cell
    import ptsb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_slot i_slot,
    output t_slot o_slot
);

    t_slot r_slot;

    // Only the active flag needs a reset; the counts are loaded on registration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.active <= 1'b0;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

>>> hw/rtl/ptsb_head.sv
// ---------------------------------------------------------------------------
// Slot head update
// Updates the slot leaving the head of the ring for a tick or a registration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptsb_head
    import ptsb_pkg::*;
(
    input  t_slot                 i_slot,
    input  logic                  i_op,
    input  logic                  i_placed,
    input  logic [INTERVAL_W-1:0] i_ticks,
    output t_slot                 o_slot,
    output t_head_res             o_res
);

    logic [INTERVAL_W-1:0] w_next;

    // The elapsed count wraps within its own width.
    assign w_next = i_slot.elapsed + INTERVAL_W'(1);

    always_comb begin
        o_slot = i_slot;
        o_res  = '0;
        if (i_op == OP_TICK) begin
            if (i_slot.active) begin
                if (w_next == i_slot.interval) begin
                    o_slot.elapsed = '0;
                    o_res.fire     = 1'b1;
                end else begin
                    o_slot.elapsed = w_next;
                end
            end
        end else if (!i_slot.active && !i_placed) begin
            o_slot.active   = 1'b1;
            o_slot.interval = i_ticks;
            o_slot.elapsed  = '0;
            o_res.place     = 1'b1;
        end
    end

endmodule

>>> hw/rtl/periodic_timer_slot_bank.sv
// ---------------------------------------------------------------------------
// Periodic timer slot bank
// A ring of timer slot cells scanned one slot per cycle for ticks and
// registrations.
// ---------------------------------------------------------------------------
// Usage: drive i_opcode and i_interval_ms and raise start; the item is taken
// at a rising edge where start is high and busy is low. A tick item
// (opcode 0) advances every active slot; a register item (opcode 1) divides
// the period by the tick length and claims the lowest free slot.
// Results appear on o_kind, o_slot and o_last for exactly one cycle with
// o_valid high; the receiver cannot stall them. o_last marks the final
// result of an item. A tick that fires nothing gives no result at all.
// Operation: the slot states sit in a ring of cells that rotates once per item,
// one slot per cycle, with SLOT_COUNT clamped to 1..16 slots in use. A tick
// scans the ring and then flushes; a registration first runs the reciprocal
// divide (S_MUL, S_QUOT) and then scans and flushes; a too-short period ends
// after S_QUOT. Each result is registered from the step that emits it; a fire
// is held back until the next fire or the flush so the final one carries
// o_last. A new item is taken only once busy is low again.
// Reset (synchronous, active low) frees every slot and drops busy and o_valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module periodic_timer_slot_bank
    import ptsb_pkg::*;
#(
    parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT,
    parameter int TICK_MS    = DEFAULT_TICK_MS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [15:0] i_interval_ms,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_slot,
    output logic        o_last
);

    localparam int USED = (SLOT_COUNT < 1) ? 1 :
                          ((SLOT_COUNT > SLOT_DEPTH) ? SLOT_DEPTH : SLOT_COUNT);
    localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(USED - 1);
    localparam int TICK_DIV = (TICK_MS < 1) ? 1 : TICK_MS;
    localparam logic [15:0] DIV_W = 16'(TICK_DIV);
    // floor(2^31 / TICK_DIV); the product estimate is short by at most one.
    localparam logic [31:0] RECIP = 32'(64'h8000_0000 / 64'(TICK_DIV));

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_QUOT  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [15:0]           r_ms, n_ms;
    logic                  r_op, n_op;
    logic [47:0]           r_prod, n_prod;
    logic [INTERVAL_W-1:0] r_ticks, n_ticks;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_placed, n_placed;
    logic                  r_pend_v, n_pend_v;
    logic [IDX_W-1:0]      r_pend_slot, n_pend_slot;
    logic                  r_valid, n_valid;
    logic [1:0]            r_kind, n_kind;
    logic [3:0]            r_slot, n_slot;
    logic                  r_last, n_last;

    logic                  w_shift;
    t_slot                 w_cell_q [USED];
    t_slot                 w_cell_d [USED];
    t_slot                 w_head_out;
    t_head_res             w_head_res;

    logic [16:0]           w_q0;
    logic [31:0]           w_qt;
    logic [31:0]           w_rem;
    logic [16:0]           w_q;
    logic [INTERVAL_W-1:0] w_ticks;

    // Ring of slot cells: each cell takes its upper neighbor, the last takes
    // the updated head, so one full rotation restores slot order.
    genvar g;
    generate
        for (g = 0; g < USED; g++) begin : g_cell
            if (g < USED - 1) begin : g_mid
                assign w_cell_d[g] = w_cell_q[g+1];
            end else begin : g_tail
                assign w_cell_d[g] = w_head_out;
            end
            ptsb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_slot  (w_cell_d[g]),
                .o_slot  (w_cell_q[g])
            );
        end
    endgenerate

    ptsb_head u_head (
        .i_slot   (w_cell_q[0]),
        .i_op     (r_op),
        .i_placed (r_placed),
        .i_ticks  (r_ticks),
        .o_slot   (w_head_out),
        .o_res    (w_head_res)
    );

    // Quotient correction: the estimate is off by at most one.
    assign w_q0    = r_prod[47:31];
    assign w_qt    = 32'(w_q0) * 32'(DIV_W);
    assign w_rem   = 32'(r_ms) - w_qt;
    assign w_q     = w_q0 + 17'(w_rem >= 32'(DIV_W));
    assign w_ticks = (w_q > 17'(INTERVAL_MAX)) ? INTERVAL_MAX : w_q[INTERVAL_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_ms        = r_ms;
        n_op        = r_op;
        n_prod      = r_prod;
        n_ticks     = r_ticks;
        n_idx       = r_idx;
        n_placed    = r_placed;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_valid     = 1'b0;
        n_kind      = r_kind;
        n_slot      = r_slot;
        n_last      = r_last;
        w_shift     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ms     = i_interval_ms;
                    n_op     = i_opcode;
                    n_idx    = '0;
                    n_placed = 1'b0;
                    n_pend_v = 1'b0;
                    n_state  = (i_opcode == OP_REGISTER) ? S_MUL : S_SCAN;
                end
            end
            S_MUL: begin
                n_prod  = 48'(r_ms) * 48'(RECIP);
                n_state = S_QUOT;
            end
            S_QUOT: begin
                if (w_q == '0) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_TOO_SHORT;
                    n_slot  = '0;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_ticks = w_ticks;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                w_shift = 1'b1;
                if (w_head_res.place) begin
                    n_valid  = 1'b1;
                    n_kind   = KIND_REGISTERED;
                    n_slot   = 4'(r_idx);
                    n_last   = 1'b1;
                    n_placed = 1'b1;
                end
                // A fire is held back until the next fire or the flush so the final one can carry last.
                if (w_head_res.fire) begin
                    if (r_pend_v) begin
                        n_valid = 1'b1;
                        n_kind  = KIND_FIRED;
                        n_slot  = 4'(r_pend_slot);
                        n_last  = 1'b0;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_slot = r_idx;
                end
                if (r_idx == IDX_LAST) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_FLUSH: begin
                if (r_op == OP_TICK && r_pend_v) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_FIRED;
                    n_slot  = 4'(r_pend_slot);
                    n_last  = 1'b1;
                end else if (r_op == OP_REGISTER && !r_placed) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_FULL;
                    n_slot  = '0;
                    n_last  = 1'b1;
                end
                n_pend_v = 1'b0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_placed <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_placed <= n_placed;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ms        <= n_ms;
        r_op        <= n_op;
        r_prod      <= n_prod;
        r_ticks     <= n_ticks;
        r_idx       <= n_idx;
        r_pend_slot <= n_pend_slot;
        r_kind      <= n_kind;
        r_slot      <= n_slot;
        r_last      <= n_last;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_slot  = r_slot;
    assign o_last  = r_last;

    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, start && !busy |=> busy, "accepted item did not raise busy")
    `ASSERT_CLK(a_single_last, i_clk, i_rst_n, o_valid && o_kind != KIND_FIRED |-> o_last, "registration result without last")
    `ASSERT_NEVER(a_pend_reg, i_clk, i_rst_n, r_pend_v && r_op == OP_REGISTER, "fire pending during a registration")
    `ASSERT_CLK(a_result_busy, i_clk, i_rst_n, o_valid |-> $past(busy), "result without an item in progress")

endmodule

>>> bench/periodic_timer_slot_bank_tb.sv
// ---------------------------------------------------------------------------
// Periodic timer slot bank testbench
// Drives tick and register items through the start/busy handshake, predicts
// every placement, rejection and fire with a local copy of the slot bank,
// and checks each strobed result in order against that prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_timer_slot_bank_tb
    import ptsb_pkg::*;
();

    localparam int BANK_SLOTS  = DEFAULT_SLOT_COUNT;
    localparam int TICK_LEN_MS = DEFAULT_TICK_MS;
    localparam int USED_SLOTS  = (BANK_SLOTS < 1) ? 1 :
                                 ((BANK_SLOTS > SLOT_DEPTH) ? SLOT_DEPTH : BANK_SLOTS);
    localparam int unsigned TICK_DIV = (TICK_LEN_MS < 1) ? 1 : TICK_LEN_MS;
    localparam int DRAIN_CYCLES = 48;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] slot;
        logic       last;
    } t_timer_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_opcode;
    logic [15:0] i_interval_ms;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [3:0]  o_slot;
    logic        o_last;

    t_slot         timer_slots [SLOT_DEPTH];
    t_timer_result pending_results [$];

    int n_errors  = 0;
    int n_items   = 0;
    int n_ticks   = 0;
    int n_placed  = 0;
    int n_short   = 0;
    int n_full    = 0;
    int n_fires   = 0;
    int n_checked = 0;

    periodic_timer_slot_bank #(
        .SLOT_COUNT(BANK_SLOTS),
        .TICK_MS   (TICK_LEN_MS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_interval_ms(i_interval_ms),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_slot       (o_slot),
        .o_last       (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (n_errors < PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
        n_errors++;
    endtask

    function automatic void queue_result(input logic [1:0] kind, input logic [3:0] slot,
                                         input logic last);
        t_timer_result res;
        res.kind = kind;
        res.slot = slot;
        res.last = last;
        pending_results.push_back(res);
    endfunction

    // Updates the local slot bank for one accepted item and queues what it must emit.
    function automatic void predict_timer(input logic op, input logic [15:0] ms);
        int unsigned ticks;
        int          fired;
        fired = 0;
        if (op == OP_REGISTER) begin
            ticks = ms / TICK_DIV;
            if (ticks == 0) begin
                queue_result(KIND_TOO_SHORT, 4'd0, 1'b1);
                n_short++;
                return;
            end
            if (ticks > INTERVAL_MAX) begin
                ticks = INTERVAL_MAX;
            end
            for (int i = 0; i < USED_SLOTS; i++) begin
                if (!timer_slots[i].active) begin
                    timer_slots[i].active   = 1'b1;
                    timer_slots[i].interval = ticks[INTERVAL_W-1:0];
                    timer_slots[i].elapsed  = '0;
                    queue_result(KIND_REGISTERED, 4'(i), 1'b1);
                    n_placed++;
                    return;
                end
            end
            queue_result(KIND_FULL, 4'd0, 1'b1);
            n_full++;
            return;
        end
        n_ticks++;
        for (int i = 0; i < USED_SLOTS; i++) begin
            if (timer_slots[i].active) begin
                timer_slots[i].elapsed = timer_slots[i].elapsed + 1'b1;
                if (timer_slots[i].elapsed == timer_slots[i].interval) begin
                    timer_slots[i].elapsed = '0;
                    queue_result(KIND_FIRED, 4'(i), 1'b0);
                    fired++;
                end
            end
        end
        // Only the final fire of a tick carries the last flag.
        if (fired > 0) begin
            pending_results[pending_results.size() - 1].last = 1'b1;
        end
        n_fires += fired;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with start still high.
    task automatic send_item(input logic op, input logic [15:0] ms);
        start         <= 1'b1;
        i_opcode      <= op;
        i_interval_ms <= ms;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        predict_timer(op, ms);
        n_items++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_timer_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d slot %0d last %0d",
                                          o_kind, o_slot, o_last));
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_kind !== want.kind) begin
                    report_mismatch($sformatf("kind %0d, expected %0d (slot %0d)",
                                              o_kind, want.kind, want.slot));
                end
                if (o_slot !== want.slot) begin
                    report_mismatch($sformatf("slot %0d, expected %0d (kind %0d)",
                                              o_slot, want.slot, want.kind));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("last %0d, expected %0d (kind %0d slot %0d)",
                                              o_last, want.last, want.kind, want.slot));
                end
            end
        end
    end

    task automatic test_too_short_periods();
        send_item(OP_REGISTER, 16'd0);
        send_item(OP_REGISTER, 16'(TICK_LEN_MS - 1));
        // No slot is active yet, so this tick must stay silent.
        send_item(OP_TICK, 16'hFFFF);
    endtask

    task automatic test_register_extremes();
        send_item(OP_REGISTER, 16'(TICK_LEN_MS));
        send_item(OP_REGISTER, 16'hFFFF);
        send_item(OP_REGISTER, 16'(2 * TICK_LEN_MS));
        send_item(OP_REGISTER, 16'(3 * TICK_LEN_MS - 1));
    endtask

    task automatic test_tick_fires();
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'hA5A5);
        send_item(OP_TICK, 16'h5A5A);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct);
        int          short_ticks [7] = '{1, 2, 3, 4, 6, 8, 12};
        logic        op;
        logic [15:0] ms;
        for (int k = 0; k < count; k++) begin
            op = ($urandom_range(0, 99) < 28) ? OP_REGISTER : OP_TICK;
            ms = 16'($urandom);
            if (op == OP_REGISTER) begin
                if (n_placed < USED_SLOTS) begin
                    // Mostly short periods so that slots fire often and together.
                    if ($urandom_range(0, 7) != 0) begin
                        ms = 16'(short_ticks[$urandom_range(0, 6)] * TICK_LEN_MS
                                 + $urandom_range(0, TICK_LEN_MS - 1));
                    end
                end else if ($urandom_range(0, 3) == 0) begin
                    ms = 16'($urandom_range(0, TICK_LEN_MS - 1));
                end
            end
            send_item(op, ms);
            if ($urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 24)) @(negedge i_clk);
            end
        end
    endtask

    task automatic test_bank_full();
        send_item(OP_REGISTER, 16'hFFFF);
        // The short period is reported even when no slot is free.
        send_item(OP_REGISTER, 16'(TICK_LEN_MS - 1));
        send_item(OP_REGISTER, 16'(TICK_LEN_MS));
        send_item(OP_TICK, 16'h0000);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_opcode      = OP_TICK;
        i_interval_ms = '0;
        for (int i = 0; i < SLOT_DEPTH; i++) begin
            timer_slots[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_too_short_periods();
        test_register_extremes();
        test_tick_fires();
        test_random_traffic(140, 0);
        test_random_traffic(140, 66);
        test_random_traffic(140, 16);
        test_bank_full();
        start <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d ticks, %0d placements, %0d too short, %0d bank full.",
                 n_items, n_ticks, n_placed, n_short, n_full);
        $display("Checked %0d results including %0d timer fires, over three idle mixes.",
                 n_checked, n_fires);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("** periodic_timer_slot_bank: PASSED **");
        end else begin
            $display("** periodic_timer_slot_bank: FAILED **");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Timeout with %0d results still expected.", pending_results.size());
        $display("** periodic_timer_slot_bank: FAILED **");
        $finish;
    end

endmodule
